@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dmic_pkg.sv @@
// ----------------------------------------------------------------------------
// dmic_pkg
// Shared widths, codes and controller/datapath bundles of the instruction
// cache tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmic_pkg;

  localparam int DEF_ROWS         = 4096;
  localparam int DEF_ADDRESS_BITS = 32;

  localparam int ADDR_W          = 32;
  localparam int CMD_W           = 2;
  localparam int OUTCOME_W       = 2;
  localparam int CNT_W           = 32;
  localparam int OFFSET_BITS     = 2;
  localparam int MAX_INDEX_BITS  = 12;
  localparam int MAX_WORD_BITS   = 4;
  localparam int INDEX_BITS_W    = 4;
  localparam int WORD_BITS_W     = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 4;

  // Access commands.
  localparam logic [CMD_W-1:0] CMD_FETCH      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA_WRITE = 2'd2;

  // Lookup outcomes.
  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT        = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_COMPULSORY = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_CONFLICT   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS_LOG2 = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic recip;
    logic reduce;
    logic read;
    logic commit;
  } dmic_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_fetch;
    logic out_free;
  } dmic_sts_t;

endpackage

@@ rtl/core/dmic_in_if.sv @@
// ----------------------------------------------------------------------------
// dmic_in_if
// Access channel: one beat carries a command and a byte address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmic_in_if
  import dmic_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

@@ rtl/core/dmic_out_if.sv @@
// ----------------------------------------------------------------------------
// dmic_out_if
// Result channel: one beat carries the outcome and the four statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmic_out_if
  import dmic_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [CNT_W-1:0]     fetch_count;
  logic [CNT_W-1:0]     compulsory_count;
  logic [CNT_W-1:0]     conflict_count;
  logic [CNT_W-1:0]     words_loaded;

  modport source (output valid, output outcome, output fetch_count,
                  output compulsory_count, output conflict_count,
                  output words_loaded, input ready);
  modport sink   (input valid, input outcome, input fetch_count,
                  input compulsory_count, input conflict_count,
                  input words_loaded, output ready);
endinterface

@@ rtl/core/dmic_ctrl.sv @@
// ----------------------------------------------------------------------------
// dmic_ctrl
// Sequencer of the tag store: clearing pass, then one access at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmic_ctrl
  import dmic_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  dmic_sts_t sts,
  output logic      in_ready,
  output dmic_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RECIP,
    ST_REDUCE,
    ST_READ,
    ST_UPDATE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        // Data accesses are taken and dropped; only fetches start a lookup.
        if (in_valid && sts.is_fetch) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_RECIP;
        end
      end
      ST_RECIP: begin
        cmd.recip = 1'b1;
        state_nxt = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        state_nxt  = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/dmic_dp.sv @@
// ----------------------------------------------------------------------------
// dmic_dp
// Datapath of the tag store: address split, row reduction, tag memory,
// saturating statistics and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmic_dp
  import dmic_pkg::*;
#(
  parameter int ROWS         = DEF_ROWS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dmic_cmd_t             cmd,
  output dmic_sts_t             sts,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUTCOME_W-1:0]  out_outcome,
  output logic [CNT_W-1:0]      out_fetch_count,
  output logic [CNT_W-1:0]      out_compulsory_count,
  output logic [CNT_W-1:0]      out_conflict_count,
  output logic [CNT_W-1:0]      out_words_loaded
);

  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EFF_AB      = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int TAG_W       = EFF_AB - OFFSET_BITS;
  localparam int RAW_W       = MAX_INDEX_BITS;
  localparam int RECIP_SHIFT = 2 * MAX_INDEX_BITS;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = RAW_W + RECIP_W;
  localparam int SHIFT_W     = 5;

  localparam logic [ADDR_W-1:0]  ADDR_MASK = ADDR_W'((64'd1 << EFF_AB) - 64'd1);
  // Rounded-up reciprocal: exact quotient for every row value below 2^12.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(ROWS) - 64'd1) / 64'(ROWS));
  localparam logic [RAW_W-1:0]   ROWS_LO = RAW_W'(ROWS);

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // Configuration.
  logic [INDEX_BITS_W-1:0] index_bits_r;
  logic [WORD_BITS_W-1:0]  words_log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r <= INDEX_BITS_W'(MAX_INDEX_BITS);
      words_log2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INDEX_BITS:       index_bits_r <= cfg_wdata[INDEX_BITS_W-1:0];
        CFG_BLOCK_WORDS_LOG2: words_log2_r <= cfg_wdata[WORD_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Address split at capture, with oversized settings clamped.
  logic [WORD_BITS_W-1:0]  wb;
  logic [INDEX_BITS_W-1:0] rb;
  logic [SHIFT_W-1:0]      row_lsb, tag_lsb;
  logic [RAW_W-1:0]        row_sel_mask, row_raw;
  logic [TAG_W-1:0]        tag;

  always_comb begin
    wb = (words_log2_r > WORD_BITS_W'(MAX_WORD_BITS)) ? WORD_BITS_W'(MAX_WORD_BITS)
                                                      : words_log2_r;
    rb = (index_bits_r > INDEX_BITS_W'(MAX_INDEX_BITS)) ? INDEX_BITS_W'(MAX_INDEX_BITS)
                                                        : index_bits_r;
    row_lsb      = SHIFT_W'(OFFSET_BITS) + SHIFT_W'(wb);
    tag_lsb      = row_lsb + SHIFT_W'(rb);
    row_sel_mask = RAW_W'((13'd1 << rb) - 13'd1);
    row_raw      = RAW_W'(in_address >> row_lsb) & row_sel_mask;
    tag          = TAG_W'((in_address & ADDR_MASK) >> tag_lsb);
  end

  logic [RAW_W-1:0]       row_raw_r;
  logic [TAG_W-1:0]       tag_r;
  logic [WORD_BITS_W-1:0] wb_r;
  logic [RAW_W-1:0]       quot_r;
  logic [ROW_W-1:0]       row_r;
  logic [PROD_W-1:0]      recip_prod;
  logic [RAW_W-1:0]       quot_rows_lo;

  // Row modulo ROWS: quotient by reciprocal, then subtract quotient * ROWS.
  // The remainder is below 2^12, so 12-bit arithmetic suffices.
  assign recip_prod   = PROD_W'(row_raw_r) * PROD_W'(RECIP);
  assign quot_rows_lo = quot_r * ROWS_LO;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_raw_r <= row_raw;
      tag_r     <= tag;
      wb_r      <= wb;
    end
    if (cmd.recip) begin
      quot_r <= RAW_W'(recip_prod >> RECIP_SHIFT);
    end
    if (cmd.reduce) begin
      row_r <= ROW_W'(row_raw_r - quot_rows_lo);
    end
  end

  // Tag memory: {valid, tag} per row, cleared by a pass after reset.
  logic [TAG_W:0]   mem [ROWS];
  logic [TAG_W:0]   rd_r;
  logic [ROW_W-1:0] clr_cnt_r;
  logic             mem_we;
  logic [ROW_W-1:0] mem_waddr;
  logic [TAG_W:0]   mem_wdata;
  logic             hit, rd_valid;
  logic [TAG_W-1:0] rd_tag;

  assign rd_valid = rd_r[TAG_W];
  assign rd_tag   = rd_r[TAG_W-1:0];
  assign hit      = rd_valid && (rd_tag == tag_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_r;
    mem_wdata = {1'b1, tag_r};
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.commit && !hit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_r <= mem[row_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + ROW_W'(1);
    end
  end

  // Statistics and result register.
  logic [CNT_W-1:0]     fetch_r, comp_r, confl_r, loaded_r;
  logic [CNT_W-1:0]     fetch_nxt, comp_nxt, confl_nxt, loaded_nxt;
  logic [OUTCOME_W-1:0] outcome_nxt;
  logic                 out_valid_r;
  logic [OUTCOME_W-1:0] out_outcome_r;
  logic [CNT_W-1:0]     out_fetch_r, out_comp_r, out_confl_r, out_loaded_r;

  always_comb begin
    fetch_nxt   = sat_add(fetch_r, CNT_W'(1));
    comp_nxt    = comp_r;
    confl_nxt   = confl_r;
    loaded_nxt  = loaded_r;
    outcome_nxt = OUTCOME_HIT;
    if (!hit) begin
      loaded_nxt = sat_add(loaded_r, CNT_W'(1) << wb_r);
      if (rd_valid) begin
        outcome_nxt = OUTCOME_CONFLICT;
        confl_nxt   = sat_add(confl_r, CNT_W'(1));
      end else begin
        outcome_nxt = OUTCOME_COMPULSORY;
        comp_nxt    = sat_add(comp_r, CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_r     <= '0;
      comp_r      <= '0;
      confl_r     <= '0;
      loaded_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      fetch_r     <= fetch_nxt;
      comp_r      <= comp_nxt;
      confl_r     <= confl_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome_r <= outcome_nxt;
      out_fetch_r   <= fetch_nxt;
      out_comp_r    <= comp_nxt;
      out_confl_r   <= confl_nxt;
      out_loaded_r  <= loaded_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_outcome          = out_outcome_r;
  assign out_fetch_count      = out_fetch_r;
  assign out_compulsory_count = out_comp_r;
  assign out_conflict_count   = out_confl_r;
  assign out_words_loaded     = out_loaded_r;

  assign sts.clear_last = (clr_cnt_r == ROW_W'(ROWS - 1));
  assign sts.is_fetch   = (in_command == CMD_FETCH);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

@@ rtl/core/direct_mapped_icache_hit_miss.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_icache_hit_miss
// Direct-mapped instruction cache tag store with hit and miss statistics.
//
// Each input beat is one access. Data reads and data writes (and the unused
// command code) are taken and produce no result. An instruction fetch
// splits its address into block-word bits, a row index of index_bits bits
// and a tag, looks the row up and returns one result beat: hit, compulsory
// miss (row never filled) or conflict miss (other tag), together with
// saturating counts of fetches, compulsory misses, conflict misses and
// words loaded. A miss fills the row. From acceptance to its result a fetch
// goes through these steps: a reciprocal multiply and a subtract reduce the
// row index modulo ROWS, then the registered tag memory read, then the
// compare and update. The finished result sits in an output register, so
// the next access is taken while it waits; a further fetch stalls only at
// its update step. After reset the block clears the valid bits of the tag
// memory and takes no access during that pass; configuration writes are
// accepted at any time but belong in idle periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module direct_mapped_icache_hit_miss
  import dmic_pkg::*;
#(
  parameter int ROWS         = DEF_ROWS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dmic_in_if.sink               in_bus,
  dmic_out_if.source            out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dmic_cmd_t cmd;
  dmic_sts_t sts;

  // The controller sequences each fetch; the datapath holds every register
  // that carries address, tag or statistics.
  dmic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .sts      (sts),
    .in_ready (in_bus.ready),
    .cmd      (cmd)
  );

  dmic_dp #(
    .ROWS         (ROWS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_command           (in_bus.command),
    .in_address           (in_bus.address),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_ready            (out_bus.ready),
    .out_valid            (out_bus.valid),
    .out_outcome          (out_bus.outcome),
    .out_fetch_count      (out_bus.fetch_count),
    .out_compulsory_count (out_bus.compulsory_count),
    .out_conflict_count   (out_bus.conflict_count),
    .out_words_loaded     (out_bus.words_loaded)
  );

  // An update only happens when the result register can take it.
  `ASSERT_IMPLY(a_commit_slot_free, clk, rst_n, cmd.commit, (!out_bus.valid || out_bus.ready), "update with result register occupied")

  // A committed update shows up as a result beat in the next cycle.
  `ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_bus.valid, "update did not produce a result beat")

  // Once a fetch is taken, the block is busy with it in the next cycle.
  `ASSERT_NEXT(a_fetch_busy, clk, rst_n, (in_bus.valid && in_bus.ready && (in_bus.command == CMD_FETCH)), !in_bus.ready, "block took a second access during a lookup")

endmodule
